/* rtl/core/grm_pkg.sv */
// grm_pkg: shared types and codes for the guest register map with lru spill
// no dependencies
`default_nettype none
package grm_pkg;

    typedef enum logic [2:0] {
        MODE_ALLOC_ANY   = 3'd0,
        MODE_ALLOC_FIXED = 3'd1,
        MODE_FREE        = 3'd2,
        MODE_MARK_MOD    = 3'd3,
        MODE_MOVE        = 3'd4,
        MODE_SAVE_ALL    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ACT_DONE  = 3'd0,
        ACT_STORE = 3'd1,
        ACT_LOAD  = 3'd2,
        ACT_MOVE  = 3'd3,
        ACT_XCHG  = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_STORE,
        ST_LOAD,
        ST_SAVE,
        ST_DONE
    } state_t;

    // slot visit order for allocate-any search
    localparam int ORDER_LEN = 8;
    function automatic logic [2:0] search_slot(input logic [2:0] k);
        logic [2:0] r;
        begin
            case (k)
                3'd0: r = 3'd3;
                3'd1: r = 3'd7;
                3'd2: r = 3'd2;
                3'd3: r = 3'd6;
                3'd4: r = 3'd1;
                3'd5: r = 3'd5;
                3'd6: r = 3'd0;
                default: r = 3'd4;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/guest_register_map_lru.sv */
// guest_register_map_lru: top level, slot table with a one-slot-per-cycle sequencer
// depends on grm_pkg
`default_nettype none
// Maps guest registers onto host slots. Raise start with a request while busy is
// low; the block then emits its actions (store, load, move, exchange), one per cycle
// on out_valid, and ends with a done item that has last set. The receiver cannot
// stall: every strobed result must be taken in that cycle. An allocate-any request
// walks all eight search positions through one shared compare unit, one per cycle,
// so busy stays high through scan, decide, optional store and load, and done;
// save-all through a visit of each slot and done; the other requests through
// decide, optional store and load, and done. The done item appears in the first
// cycle with busy low, and a new request may be taken in that same cycle. The
// base register is written through cfg_valid/cfg_ready while the block is idle.
module guest_register_map_lru #(
    parameter int HOST_SLOTS = 8,
    parameter int GUEST_REGS = 16,
    parameter int AGE_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [3:0]  guest_reg,
    input  wire logic [2:0]  host_slot,
    input  wire logic [2:0]  dest_slot,
    input  wire logic        load_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    output logic [2:0]       action,
    output logic [2:0]       slot_a,
    output logic [2:0]       slot_b,
    output logic [31:0]      mem_addr,
    output logic [2:0]       chosen_slot,
    output logic             ok,
    output logic [3:0]       free_slots,
    output logic             last
);

    localparam int GW = (GUEST_REGS > 1) ? $clog2(GUEST_REGS) : 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [3:0] NSLOTS = 4'(HOST_SLOTS);

    // slot table
    logic [GW-1:0]       guest_reg_q [8];
    logic [7:0]          used_reg, used_next;
    logic [7:0]          mod_reg, mod_next;
    logic [AGE_BITS-1:0] age_reg [8];
    logic [AGE_BITS-1:0] age_next [8];
    logic [GW-1:0]       gnext [8];
    logic [3:0]          free_reg, free_next;
    logic [31:0]         base_reg;

    // request latch
    logic [2:0]    mode_reg;
    logic [GW-1:0] g_reg;
    logic [2:0]    s_reg, d_reg;
    logic          ld_reg;

    // sequencer
    grm_pkg::state_t state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic hit_reg, hit_next, gfree_reg, gfree_next, gold_reg, gold_next;
    logic [2:0] ihit_reg, ihit_next, ifree_reg, ifree_next, iold_reg, iold_next;
    logic [AGE_BITS-1:0] oldest_reg, oldest_next;
    logic [2:0] tgt_reg, tgt_next;     // slot for store/load
    logic [GW-1:0] sg_reg, sg_next;    // guest of pending store
    logic doload_reg, doload_next, dostore_reg, dostore_next;
    logic [2:0] chosen_reg, chosen_next;
    logic ok_reg, ok_next;

    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  act_reg, act_next, sa_reg, sa_next, sb_reg, sb_next;
    logic [31:0] addr_reg, addr_next;
    logic [2:0]  ch_reg, ch_next;
    logic        ok_o_reg, ok_o_next, last_reg, last_next;
    logic [3:0]  fs_reg, fs_next;

    logic [GW-1:0] g_in;
    logic accept;
    logic [2:0] cur;
    logic [AGE_BITS-1:0] cur_age;
    logic [2:0] other;
    logic other_hit;

    assign accept = start && !busy;
    assign busy   = (state_reg != grm_pkg::ST_IDLE);
    assign cfg_ready = !busy;
    assign cur    = grm_pkg::search_slot(k_reg);

    // fold guest numbers beyond the register file back into range
    always_comb
    begin
        g_in = '0;
        for (int v = 0; v < 16; v++) begin
            if (guest_reg == 4'(v)) g_in = GW'(v % GUEST_REGS);
        end
    end

    // priority finder of another slot holding the guest (fixed allocation)
    always_comb
    begin
        other = 3'd0;
        other_hit = 1'b0;
        for (int i = HOST_SLOTS - 1; i >= 0; i--) begin
            if (used_reg[i] && guest_reg_q[i] == g_reg) begin
                other = 3'(i);
                other_hit = 1'b1;
            end
        end
    end

    // saturating age of the slot under scan
    always_comb
    begin
        cur_age = (age_reg[cur] < AGE_MAX) ? age_reg[cur] + 1'b1 : age_reg[cur];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grm_pkg::ST_IDLE: if (accept) state_next = (mode == grm_pkg::MODE_ALLOC_ANY)
                ? grm_pkg::ST_SCAN : (mode == grm_pkg::MODE_SAVE_ALL) ? grm_pkg::ST_SAVE
                : grm_pkg::ST_DECIDE;
            grm_pkg::ST_SCAN: if (k_reg == 3'(grm_pkg::ORDER_LEN - 1)) state_next = grm_pkg::ST_DECIDE;
            grm_pkg::ST_DECIDE, grm_pkg::ST_STORE, grm_pkg::ST_LOAD:
            begin
                if (dostore_next) state_next = grm_pkg::ST_STORE;
                else if (doload_next) state_next = grm_pkg::ST_LOAD;
                else state_next = grm_pkg::ST_DONE;
            end
            grm_pkg::ST_SAVE: if (k_reg == 3'd7) state_next = grm_pkg::ST_DONE;
            grm_pkg::ST_DONE: state_next = grm_pkg::ST_IDLE;
            default: state_next = grm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [2:0] s;
        logic [2:0] t;
        s = s_reg;
        t = 3'd0;
        used_next = used_reg; mod_next = mod_reg; free_next = free_reg;
        for (int i = 0; i < 8; i++) begin
            age_next[i] = age_reg[i];
            gnext[i] = guest_reg_q[i];
        end
        k_next = k_reg; hit_next = hit_reg; gfree_next = gfree_reg; gold_next = gold_reg;
        ihit_next = ihit_reg; ifree_next = ifree_reg; iold_next = iold_reg;
        oldest_next = oldest_reg; tgt_next = tgt_reg; sg_next = sg_reg;
        doload_next = doload_reg; dostore_next = dostore_reg;
        chosen_next = chosen_reg; ok_next = ok_reg;
        ov_next = 1'b0; act_next = grm_pkg::ACT_DONE; sa_next = 3'd0; sb_next = 3'd0;
        addr_next = 32'd0; ch_next = 3'd0; ok_o_next = 1'b0; fs_next = 4'd0;
        last_next = 1'b0;
        case (state_reg)
            grm_pkg::ST_IDLE:
            begin
                k_next = 3'd0; hit_next = 1'b0; gfree_next = 1'b0; gold_next = 1'b0;
                oldest_next = '0; doload_next = 1'b0; dostore_next = 1'b0;
                chosen_next = 3'd0; ok_next = 1'b1;
            end
            grm_pkg::ST_SCAN:
            begin
                k_next = k_reg + 3'd1;
                if (32'(cur) < HOST_SLOTS) begin
                    age_next[cur] = cur_age;
                    if (used_reg[cur] && guest_reg_q[cur] == g_reg) begin
                        hit_next = 1'b1; ihit_next = cur;
                    end else if (!used_reg[cur]) begin
                        gfree_next = 1'b1; ifree_next = cur;
                    end else if (!gold_reg || cur_age > oldest_reg) begin
                        gold_next = 1'b1; oldest_next = cur_age; iold_next = cur;
                    end
                end
            end
            grm_pkg::ST_DECIDE:
            begin
                case (mode_reg)
                    grm_pkg::MODE_ALLOC_ANY:
                    begin
                        t = hit_reg ? ihit_reg : gfree_reg ? ifree_reg : iold_reg;
                        chosen_next = t;
                        if (hit_reg) age_next[t] = '0;
                        else begin
                            dostore_next = !gfree_reg && mod_reg[t];
                            sg_next = guest_reg_q[t];
                            if (gfree_reg) free_next = free_reg - 4'd1;
                            used_next[t] = 1'b1; mod_next[t] = 1'b0; age_next[t] = '0;
                            gnext[t] = g_reg; doload_next = ld_reg;
                        end
                        tgt_next = t;
                    end
                    grm_pkg::MODE_ALLOC_FIXED:
                    begin
                        chosen_next = s; tgt_next = s;
                        if (32'(s) >= HOST_SLOTS) begin
                            ok_next = 1'b0; chosen_next = 3'd0;
                        end else if (used_reg[s] && guest_reg_q[s] == g_reg) begin
                            age_next[s] = '0;
                        end else if (other_hit) begin
                            if (used_reg[s]) begin
                                gnext[s] = guest_reg_q[other]; gnext[other] = guest_reg_q[s];
                                mod_next[s] = mod_reg[other]; mod_next[other] = mod_reg[s];
                                age_next[other] = age_reg[s];
                                ov_next = 1'b1; ok_o_next = 1'b1;
                                act_next = ld_reg ? grm_pkg::ACT_XCHG : grm_pkg::ACT_MOVE;
                                sa_next = ld_reg ? s : other; sb_next = ld_reg ? other : s;
                            end else begin
                                gnext[s] = guest_reg_q[other]; used_next[s] = 1'b1;
                                mod_next[s] = mod_reg[other];
                                used_next[other] = 1'b0; mod_next[other] = 1'b0;
                                age_next[other] = '0;
                                ov_next = ld_reg; ok_o_next = 1'b1;
                                act_next = grm_pkg::ACT_MOVE; sa_next = s; sb_next = other;
                            end
                            age_next[s] = '0;
                        end else begin
                            dostore_next = used_reg[s] && mod_reg[s];
                            sg_next = guest_reg_q[s];
                            if (!used_reg[s]) free_next = free_reg - 4'd1;
                            used_next[s] = 1'b1; mod_next[s] = 1'b0; age_next[s] = '0;
                            gnext[s] = g_reg; doload_next = ld_reg;
                        end
                    end
                    grm_pkg::MODE_FREE:
                    begin
                        if (32'(s) >= HOST_SLOTS) ok_next = 1'b0;
                        else if (used_reg[s]) begin
                            dostore_next = mod_reg[s]; sg_next = guest_reg_q[s];
                            tgt_next = s; free_next = free_reg + 4'd1;
                            used_next[s] = 1'b0; mod_next[s] = 1'b0; age_next[s] = '0;
                        end
                    end
                    grm_pkg::MODE_MARK_MOD:
                    begin
                        if (32'(s) >= HOST_SLOTS) ok_next = 1'b0;
                        else mod_next[s] = 1'b1;
                    end
                    grm_pkg::MODE_MOVE:
                    begin
                        if (32'(s) >= HOST_SLOTS || 32'(d_reg) >= HOST_SLOTS ||
                            !used_reg[s] || used_reg[d_reg]) ok_next = 1'b0;
                        else begin
                            gnext[d_reg] = guest_reg_q[s]; used_next[d_reg] = 1'b1;
                            mod_next[d_reg] = mod_reg[s]; age_next[d_reg] = age_reg[s];
                            used_next[s] = 1'b0; mod_next[s] = 1'b0; age_next[s] = '0;
                            ov_next = 1'b1; ok_o_next = 1'b1;
                            act_next = grm_pkg::ACT_MOVE; sa_next = d_reg; sb_next = s;
                        end
                    end
                    default: ok_next = 1'b0;
                endcase
            end
            grm_pkg::ST_STORE:
            begin
                dostore_next = 1'b0;
                ov_next = 1'b1; ok_o_next = 1'b1; act_next = grm_pkg::ACT_STORE;
                sa_next = tgt_reg; addr_next = base_reg + 32'(sg_reg);
            end
            grm_pkg::ST_LOAD:
            begin
                doload_next = 1'b0;
                ov_next = 1'b1; ok_o_next = 1'b1; act_next = grm_pkg::ACT_LOAD;
                sa_next = tgt_reg; addr_next = base_reg + 32'(g_reg);
            end
            grm_pkg::ST_SAVE:
            begin
                k_next = k_reg + 3'd1;
                if (32'(k_reg) < HOST_SLOTS && used_reg[k_reg] && mod_reg[k_reg]) begin
                    mod_next[k_reg] = 1'b0;
                    ov_next = 1'b1; ok_o_next = 1'b1; act_next = grm_pkg::ACT_STORE;
                    sa_next = k_reg; addr_next = base_reg + 32'(guest_reg_q[k_reg]);
                end
            end
            grm_pkg::ST_DONE:
            begin
                ov_next = 1'b1; act_next = grm_pkg::ACT_DONE; ch_next = chosen_reg;
                ok_o_next = ok_reg; fs_next = free_reg; last_next = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= grm_pkg::ST_IDLE;
            used_reg <= '0; mod_reg <= '0; free_reg <= NSLOTS;
            base_reg <= '0; ov_reg <= 1'b0;
            for (int i = 0; i < 8; i++) age_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next; mod_reg <= mod_next; free_reg <= free_next;
            for (int i = 0; i < 8; i++) age_reg[i] <= age_next[i];
            if (cfg_valid && cfg_ready) base_reg <= cfg_data;
            ov_reg <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++) guest_reg_q[i] <= gnext[i];
        if (accept) begin
            mode_reg <= mode; g_reg <= g_in; s_reg <= host_slot;
            d_reg <= dest_slot; ld_reg <= load_value;
        end
        k_reg <= k_next; hit_reg <= hit_next; gfree_reg <= gfree_next; gold_reg <= gold_next;
        ihit_reg <= ihit_next; ifree_reg <= ifree_next; iold_reg <= iold_next;
        oldest_reg <= oldest_next; tgt_reg <= tgt_next; sg_reg <= sg_next;
        doload_reg <= doload_next; dostore_reg <= dostore_next;
        chosen_reg <= chosen_next; ok_reg <= ok_next;
        act_reg <= act_next; sa_reg <= sa_next; sb_reg <= sb_next; addr_reg <= addr_next;
        ch_reg <= ch_next; ok_o_reg <= ok_o_next; fs_reg <= fs_next; last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign action = act_reg; assign slot_a = sa_reg; assign slot_b = sb_reg;
    assign mem_addr = addr_reg; assign chosen_slot = ch_reg; assign ok = ok_o_reg;
    assign free_slots = fs_reg; assign last = last_reg;

    // free count matches the used flags
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg == NSLOTS - 4'($countones(used_reg)))
        else $error("free count out of step with used flags");
    // a done item always returns the block to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> !busy)
        else $error("done item while still busy");
    // no result while idle except the closing done item
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> $past(busy))
        else $error("stray result");

endmodule
`default_nettype wire
